### rtl/ttcb_pkg.sv
package ttcb_pkg;

    localparam int CHAR_W      = 8;
    localparam int RD_ROW_W    = 5;
    localparam int RD_COL_W    = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [CHAR_W-1:0] BACKSPACE_RESET = 8'd8;
    localparam logic [CHAR_W-1:0] ENTER_RESET     = 8'd13;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKSPACE_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTER_CODE     = 2'd2;

endpackage

### rtl/ttcb_cell_ram.sv
module ttcb_cell_ram
    import ttcb_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/text_terminal_char_buffer.sv
// Channel     Direction  Handshake              Payload
// item        in         start && !busy         func, char_code, read_row, read_col
// result      out        done (one cycle)       cell_char, cursor_column, cursor_line
// config      in         cfg_write              cfg_index, cfg_data
//
// One item is taken per cycle while busy is low; its result appears on done in the following cycle.
// The cell RAM has one write port, so a new line that scrolls holds busy high
// while the new bottom row is written with spaces.
// Scrolling itself only moves a top-row pointer; no cells are copied.
// After reset busy stays high while the whole RAM is cleared.
// Configuration writes are taken in every cycle; results cannot be held off.
module text_terminal_char_buffer
    import ttcb_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [RD_ROW_W-1:0]    read_row,
    input  logic [RD_COL_W-1:0]    read_col,
    output logic                   done,
    output logic [CHAR_W-1:0]      cell_char,
    output logic [RD_COL_W-1:0]    cursor_column,
    output logic [RD_ROW_W-1:0]    cursor_line,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    typedef enum logic [0:0] {
        ST_CLEAR,
        ST_IDLE
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] clr_end_reg, clr_end_next;
    logic              done_reg, done_next;
    logic              read_hit_reg, read_hit_next;
    logic              scroll_en_reg;
    logic [CHAR_W-1:0] bs_code_reg;
    logic [CHAR_W-1:0] enter_code_reg;

    logic              accept;
    logic              in_range;
    logic              new_line;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    // Logical rows are stored at an offset of top_reg, modulo ROWS.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                    input logic [ROW_W-1:0] lrow,
                                                    input logic [COL_W-1:0] col);
        logic [ROW_W:0] sum;
        logic [ROW_W:0] prow;
        sum  = {1'b0, top} + {1'b0, lrow};
        prow = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
        return ADDR_W'(32'(prow) * COLUMNS + 32'(col));
    endfunction

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);

    always_comb
    begin
        state_next    = state_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        top_next      = top_reg;
        clr_addr_next = clr_addr_reg;
        clr_end_next  = clr_end_reg;
        done_next     = accept;
        read_hit_next = 1'b0;
        new_line      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cell_addr(top_reg, cur_row_reg, cur_col_reg);
        mem_wdata     = char_code;
        mem_re        = 1'b0;
        mem_raddr     = cell_addr(top_reg, ROW_W'(read_row), COL_W'(read_col));

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = SPACE_CODE;
                if (clr_addr_reg == clr_end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_READ)
                    begin
                        mem_re        = in_range;
                        read_hit_next = in_range;
                    end
                    else if (char_code == bs_code_reg)
                    begin
                        if (cur_col_reg != '0)
                        begin
                            cur_col_next = cur_col_reg - 1'b1;
                        end
                    end
                    else if (char_code == NEWLINE_CODE || char_code == enter_code_reg)
                    begin
                        new_line = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (cur_col_reg == LAST_COL)
                        begin
                            new_line = 1'b1;
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end

                    if (new_line)
                    begin
                        cur_col_next = '0;
                        if (cur_row_reg != LAST_ROW)
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                        else if (scroll_en_reg)
                        begin
                            // The old top row becomes the new bottom row and is blanked.
                            top_next      = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                            clr_addr_next = ADDR_W'(32'(top_reg) * COLUMNS);
                            clr_end_next  = ADDR_W'(32'(top_reg) * COLUMNS + COLUMNS - 1);
                            state_next    = ST_CLEAR;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            top_reg      <= '0;
            clr_addr_reg <= '0;
            clr_end_reg  <= LAST_ADDR;
            done_reg     <= 1'b0;
            read_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            top_reg      <= top_next;
            clr_addr_reg <= clr_addr_next;
            clr_end_reg  <= clr_end_next;
            done_reg     <= done_next;
            read_hit_reg <= read_hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_en_reg  <= 1'b0;
            bs_code_reg    <= BACKSPACE_RESET;
            enter_code_reg <= ENTER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCROLL_ENABLE:  scroll_en_reg  <= cfg_data[0];
                REG_BACKSPACE_CODE: bs_code_reg    <= cfg_data;
                REG_ENTER_CODE:     enter_code_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    ttcb_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign done          = done_reg;
    assign cell_char     = read_hit_reg ? mem_rdata : '0;
    assign cursor_column = RD_COL_W'(cur_col_reg);
    assign cursor_line   = RD_ROW_W'(cur_row_reg);

    // Every accepted transaction gives exactly one result in the next cycle.
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction produced no result");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result without an accepted transaction");

    // A clearing pass never runs past the end of its range.
    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (clr_addr_reg <= clr_end_reg))
        else $error("clearing pass overran its end address");

    // A scroll starts a one-row clear and moves the top pointer.
    a_scroll_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_CLEAR)
        |=> (clr_end_reg - clr_addr_reg == ADDR_W'(COLUMNS - 1)) && !$stable(top_reg))
        else $error("scroll did not start a one-row clear");

endmodule
